@@ rtl/core/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared shorthand for clocked assertions with reset disable.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/rdpd_pkg.sv @@
// ----------------------------------------------------------------------------
// rdpd_pkg
// Types, constants and the delta decode step of the run/delta pixel decoder.
// ----------------------------------------------------------------------------
package rdpd_pkg;

  // Field widths.
  localparam int ByteW     = 8;
  localparam int PixW      = 16;
  localparam int LaneCntW  = 3;
  localparam int NumFields = 4;
  localparam int AddrW     = 3;
  localparam int DataW     = 32;

  // Default lane count and reset values of the registers.
  localparam int DefLanes = 4;
  localparam logic [ByteW-1:0] RunMarkerRst     = 8'hA5;
  localparam logic [ByteW-1:0] LiteralMarkerRst = 8'h5A;

  // Register indexes (paddr bit 2).
  localparam logic REG_RUN_MARKER     = 1'b0;
  localparam logic REG_LITERAL_MARKER = 1'b1;

  // Escape phase codes shared by run and delta stages.
  localparam logic [1:0] PH_PLAIN  = 2'd0;
  localparam logic [1:0] PH_FIRST  = 2'd1;
  localparam logic [1:0] PH_SECOND = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXPAND,
    ST_FINISH
  } ctrl_state_e;

  typedef struct packed {
    logic [ByteW-1:0] run_marker;
    logic [ByteW-1:0] literal_marker;
  } cfg_t;

  // Commands from controller to datapath.
  typedef struct packed {
    logic load;
    logic step;
    logic finish;
  } cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic start_run;
    logic last_copy;
    logic out_free;
  } sts_t;

  typedef struct packed {
    logic [1:0]       phase;
    logic [ByteW-1:0] pend;
    logic [PixW-1:0]  prev;
    logic             pix_vld;
    logic [PixW-1:0]  pix;
  } delta_res_t;

  // One byte through the delta stage. Phase code 3 acts as plain.
  function automatic delta_res_t delta_step(logic [1:0] phase, logic [ByteW-1:0] pend,
                                            logic [PixW-1:0] prev, logic [ByteW-1:0] b,
                                            logic [ByteW-1:0] lit);
    delta_res_t r;
    r.phase   = PH_PLAIN;
    r.pend    = pend;
    r.prev    = prev;
    r.pix_vld = 1'b0;
    r.pix     = prev;
    unique case (phase)
      PH_FIRST: begin
        r.pend  = b;
        r.phase = PH_SECOND;
      end
      PH_SECOND: begin
        r.pix     = {b, pend};
        r.pix_vld = 1'b1;
        r.prev    = {b, pend};
      end
      default: begin
        if (b == lit) begin
          r.phase = PH_FIRST;
        end else begin
          r.pix     = prev + {{(PixW-ByteW){b[ByteW-1]}}, b};
          r.pix_vld = 1'b1;
          r.prev    = r.pix;
        end
      end
    endcase
    return r;
  endfunction

endpackage

@@ rtl/core/rdpd_if.sv @@
// ----------------------------------------------------------------------------
// rdpd_in_if / rdpd_out_if
// Valid/ready channels carrying stream bytes in and pixel beats out.
// ----------------------------------------------------------------------------
interface rdpd_in_if import rdpd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] in_byte;
  logic             stream_end;

  modport source (output valid, in_byte, stream_end, input ready);
  modport sink   (input valid, in_byte, stream_end, output ready);
endinterface

interface rdpd_out_if import rdpd_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [PixW-1:0]     pixel_a;
  logic [PixW-1:0]     pixel_b;
  logic [PixW-1:0]     pixel_c;
  logic [PixW-1:0]     pixel_d;
  logic [LaneCntW-1:0] lane_count;
  logic                last_of_input;
  logic                stream_done;

  modport source (output valid, pixel_a, pixel_b, pixel_c, pixel_d, lane_count,
                  last_of_input, stream_done, input ready);
  modport sink   (input valid, pixel_a, pixel_b, pixel_c, pixel_d, lane_count,
                  last_of_input, stream_done, output ready);
endinterface

@@ rtl/core/rdpd_cfg.sv @@
// ----------------------------------------------------------------------------
// rdpd_cfg
// Marker registers behind the APB-style configuration port.
// ----------------------------------------------------------------------------
module rdpd_cfg import rdpd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output cfg_t             cfg_o
);

  cfg_t cfg_q, cfg_d;
  logic wr_en;

  // A write lands in the access phase; pready is tied high.
  assign wr_en = psel & penable & pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (paddr[2])
        REG_RUN_MARKER:     cfg_d.run_marker     = pwdata[ByteW-1:0];
        REG_LITERAL_MARKER: cfg_d.literal_marker = pwdata[ByteW-1:0];
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.run_marker     <= RunMarkerRst;
      cfg_q.literal_marker <= LiteralMarkerRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Read data mux.
  always_comb begin
    unique case (paddr[2])
      REG_RUN_MARKER:     prdata = {{(DataW-ByteW){1'b0}}, cfg_q.run_marker};
      REG_LITERAL_MARKER: prdata = {{(DataW-ByteW){1'b0}}, cfg_q.literal_marker};
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

@@ rtl/core/rdpd_ctrl.sv @@
// ----------------------------------------------------------------------------
// rdpd_ctrl
// Sequencer: takes bytes, walks the copies of a run, then closes the item.
// ----------------------------------------------------------------------------
module rdpd_ctrl import rdpd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  ctrl_state_e state_q, state_d;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i && sts_i.out_free && sts_i.start_run) state_d = ST_EXPAND;
      end
      ST_EXPAND: begin
        if (sts_i.out_free && sts_i.last_copy) state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (sts_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs. Every step waits for a free output register.
  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = sts_i.out_free;
        cmd_o.load = in_valid_i & sts_i.out_free;
      end
      ST_EXPAND: cmd_o.step   = sts_i.out_free;
      ST_FINISH: cmd_o.finish = sts_i.out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ rtl/core/rdpd_dp.sv @@
// ----------------------------------------------------------------------------
// rdpd_dp
// Decoder state, run copy counter, lane packing buffer and output register.
// ----------------------------------------------------------------------------
module rdpd_dp import rdpd_pkg::*; #(
  parameter int NumLanes = DefLanes
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cfg_t                cfg_i,
  input  cmd_t                cmd_i,
  output sts_t                sts_o,
  input  logic [ByteW-1:0]    in_byte_i,
  input  logic                stream_end_i,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output logic [PixW-1:0]     out_pix_o [NumFields],
  output logic [LaneCntW-1:0] out_cnt_o,
  output logic                out_last_o,
  output logic                out_done_o
);

  localparam int CntW = $clog2(NumLanes + 1);

  // Decoder state.
  logic [1:0]       run_phase_q, run_phase_d;
  logic [ByteW-1:0] run_len_q, run_len_d;
  logic [1:0]       delta_phase_q, delta_phase_d;
  logic [ByteW-1:0] pend_q, pend_d;
  logic [PixW-1:0]  prev_q, prev_d;

  // Run expansion.
  logic [ByteW-1:0] rep_val_q, rep_val_d;
  logic [ByteW-1:0] rem_q, rem_d;
  logic             end_q, end_d;

  // Lane packing buffer.
  logic [PixW-1:0]  lane_q [NumLanes];
  logic [PixW-1:0]  lane_d [NumLanes];
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [PixW-1:0]  buf_pix [NumFields];

  // Output register.
  logic                out_valid_q, out_valid_d;
  logic [PixW-1:0]     out_pix_q [NumFields];
  logic [LaneCntW-1:0] out_cnt_q;
  logic                out_last_q, out_done_q;

  // Beat to load into the output register.
  logic                emit;
  logic [PixW-1:0]     e_pix [NumFields];
  logic [LaneCntW-1:0] e_cnt;
  logic                e_last, e_done;

  logic       use_delta, clr;
  logic       out_free;
  delta_res_t dres;

  assign out_free = ~out_valid_q | out_ready_i;

  assign sts_o.start_run = (run_phase_q == PH_SECOND);
  assign sts_o.last_copy = (rem_q == '0);
  assign sts_o.out_free  = out_free;

  // Buffered lanes, zero at and above the fill count.
  for (genvar g = 0; g < NumFields; g++) begin : g_buf
    if (g < NumLanes) begin : g_used
      assign buf_pix[g] = (CntW'(g) < cnt_q) ? lane_q[g] : '0;
    end else begin : g_unused
      assign buf_pix[g] = '0;
    end
  end

  // The delta stage sees the new byte on load and the run byte while expanding.
  assign dres = delta_step(delta_phase_q, pend_q, prev_q,
                           cmd_i.load ? in_byte_i : rep_val_q, cfg_i.literal_marker);

  always_comb begin
    run_phase_d   = run_phase_q;
    run_len_d     = run_len_q;
    delta_phase_d = delta_phase_q;
    pend_d        = pend_q;
    prev_d        = prev_q;
    rep_val_d     = rep_val_q;
    rem_d         = rem_q;
    end_d         = end_q;
    lane_d        = lane_q;
    cnt_d         = cnt_q;
    emit          = 1'b0;
    e_pix         = '{default: '0};
    e_cnt         = '0;
    e_last        = 1'b0;
    e_done        = 1'b0;
    use_delta     = 1'b0;
    clr           = 1'b0;

    if (cmd_i.load) begin
      if (sts_o.start_run) begin
        // Value byte of a run: expand it over the following cycles.
        rep_val_d   = in_byte_i;
        rem_d       = run_len_q;
        end_d       = stream_end_i;
        run_phase_d = PH_PLAIN;
      end else begin
        unique case (run_phase_q)
          PH_FIRST: begin
            run_len_d   = in_byte_i;
            run_phase_d = PH_SECOND;
          end
          default: begin
            if (in_byte_i == cfg_i.run_marker) begin
              run_phase_d = PH_FIRST;
            end else begin
              run_phase_d = PH_PLAIN;
              use_delta   = 1'b1;
            end
          end
        endcase
        if (use_delta) begin
          delta_phase_d = dres.phase;
          pend_d        = dres.pend;
          prev_d        = dres.prev;
        end
        // A single byte gives one pixel at most; stream end always reports.
        if ((use_delta && dres.pix_vld) || stream_end_i) begin
          emit     = 1'b1;
          e_pix[0] = (use_delta && dres.pix_vld) ? dres.pix : '0;
          e_cnt    = (use_delta && dres.pix_vld) ? LaneCntW'(1) : '0;
          e_last   = 1'b1;
          e_done   = stream_end_i;
        end
        clr = stream_end_i;
      end
    end else if (cmd_i.step) begin
      // One copy of the run byte per cycle while the output register is free.
      delta_phase_d = dres.phase;
      pend_d        = dres.pend;
      prev_d        = dres.prev;
      if (!sts_o.last_copy) rem_d = rem_q - 1'b1;
      if (dres.pix_vld) begin
        if (cnt_q == CntW'(NumLanes)) begin
          // Buffer full and more pixels follow: send it as a middle beat.
          emit      = 1'b1;
          e_pix     = buf_pix;
          e_cnt     = LaneCntW'(cnt_q);
          lane_d[0] = dres.pix;
          cnt_d     = CntW'(1);
        end else begin
          for (int k = 0; k < NumLanes; k++) begin
            if (CntW'(k) == cnt_q) lane_d[k] = dres.pix;
          end
          cnt_d = cnt_q + 1'b1;
        end
      end
    end else if (cmd_i.finish) begin
      // Close the run: remaining lanes, or an empty beat at stream end.
      if ((cnt_q != '0) || end_q) begin
        emit   = 1'b1;
        e_pix  = buf_pix;
        e_cnt  = LaneCntW'(cnt_q);
        e_last = 1'b1;
        e_done = end_q;
      end
      cnt_d = '0;
      clr   = end_q;
    end

    // Stream end drops open escapes and returns the state to reset.
    if (clr) begin
      run_phase_d   = PH_PLAIN;
      run_len_d     = '0;
      delta_phase_d = PH_PLAIN;
      pend_d        = '0;
      prev_d        = '0;
    end
  end

  assign out_valid_d = emit | (out_valid_q & ~out_ready_i);

  // Control and decoder state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_phase_q   <= PH_PLAIN;
      run_len_q     <= '0;
      delta_phase_q <= PH_PLAIN;
      pend_q        <= '0;
      prev_q        <= '0;
      rem_q         <= '0;
      end_q         <= 1'b0;
      cnt_q         <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      run_phase_q   <= run_phase_d;
      run_len_q     <= run_len_d;
      delta_phase_q <= delta_phase_d;
      pend_q        <= pend_d;
      prev_q        <= prev_d;
      rem_q         <= rem_d;
      end_q         <= end_d;
      cnt_q         <= cnt_d;
      out_valid_q   <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    rep_val_q <= rep_val_d;
    lane_q    <= lane_d;
    if (emit) begin
      out_pix_q  <= e_pix;
      out_cnt_q  <= e_cnt;
      out_last_q <= e_last;
      out_done_q <= e_done;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_pix_o   = out_pix_q;
  assign out_cnt_o   = out_cnt_q;
  assign out_last_o  = out_last_q;
  assign out_done_o  = out_done_q;

endmodule

@@ rtl/core/rle_delta_pixel_decoder.sv @@
// ----------------------------------------------------------------------------
// rle_delta_pixel_decoder
// Run expansion followed by delta decoding of a byte stream into 16-bit
// pixels, packed up to four per output beat.
// ----------------------------------------------------------------------------
//   Channel  Dir  Handshake        Payload
//   in_ch    in   valid/ready      in_byte, stream_end
//   out_ch   out  valid/ready      pixel_a..pixel_d, lane_count, last_of_input,
//                                  stream_done
//   APB      in   psel/penable     paddr, pwdata -> prdata (pready tied high)
//
// A byte outside a run's value position is taken in one step; bytes follow back to
// back while the output register drains.
// The value byte of a run with count c is taken, then its c+1 copies go through
// the delta stage at one a cycle, then a closing step sends any lanes left as the last beat.
// Any step waits while the output register holds a beat that is not taken.
// Reset returns both markers to their defaults and all decoder state to zero.
// ----------------------------------------------------------------------------
module rle_delta_pixel_decoder import rdpd_pkg::*; #(
  parameter int LANES = DefLanes
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  rdpd_in_if.sink          in_ch,
  rdpd_out_if.source       out_ch,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready
);

  // Lanes per beat, clamped between one and the four pixel fields.
  localparam int EffLanes = (LANES < 1) ? 1 : ((LANES > NumFields) ? NumFields : LANES);

  cfg_t            cfg;
  cmd_t            cmd;
  sts_t            sts;
  logic [PixW-1:0] out_pix [NumFields];

  assign pready = 1'b1;

  rdpd_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg_o   (cfg)
  );

  rdpd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_ch.valid),
    .in_ready_o (in_ch.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  rdpd_dp #(
    .NumLanes (EffLanes)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .in_byte_i    (in_ch.in_byte),
    .stream_end_i (in_ch.stream_end),
    .out_ready_i  (out_ch.ready),
    .out_valid_o  (out_ch.valid),
    .out_pix_o    (out_pix),
    .out_cnt_o    (out_ch.lane_count),
    .out_last_o   (out_ch.last_of_input),
    .out_done_o   (out_ch.stream_done)
  );

  assign out_ch.pixel_a = out_pix[0];
  assign out_ch.pixel_b = out_pix[1];
  assign out_ch.pixel_c = out_pix[2];
  assign out_ch.pixel_d = out_pix[3];

endmodule

@@ rtl/core/rdpd_checker.sv @@
// ----------------------------------------------------------------------------
// rdpd_checker
// Port-level checks on the decoder's output beats, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rdpd_checker import rdpd_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid,
  input logic                out_ready,
  input logic [PixW-1:0]     pixel_a,
  input logic [PixW-1:0]     pixel_d,
  input logic [LaneCntW-1:0] lane_count,
  input logic                last_of_input,
  input logic                stream_done
);

  // A beat never claims more lanes than there are pixel fields.
  `ASSERT_IMPL(a_lane_count_max, out_valid, lane_count <= LaneCntW'(NumFields), "lane_count above four")

  // An empty beat only reports the end of a stream.
  `ASSERT_IMPL(a_empty_is_end, out_valid && lane_count == '0, stream_done && last_of_input && pixel_a == '0, "empty beat outside stream end")

  // The last lane (pixel_d) reads as zero when it is unused.
  `ASSERT_IMPL(a_unused_zero, out_valid && lane_count < LaneCntW'(NumFields), pixel_d == '0, "unused lane not zero")

  // The stream end marker sits on the final beat of its byte.
  `ASSERT_IMPL(a_done_is_last, out_valid && stream_done, last_of_input, "stream_done without last_of_input")

  // A stalled beat stays valid with pixel_a and lane_count unchanged.
  `ASSERT_NEXT(a_stall_hold, out_valid && !out_ready, out_valid && $stable(pixel_a) && $stable(lane_count), "beat changed under stall")

endmodule

bind rle_delta_pixel_decoder rdpd_checker u_rdpd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .pixel_a       (out_ch.pixel_a),
  .pixel_d       (out_ch.pixel_d),
  .lane_count    (out_ch.lane_count),
  .last_of_input (out_ch.last_of_input),
  .stream_done   (out_ch.stream_done)
);
